[rtl/dual_pid_speed_controller_defines.svh]
// ----------------------------------------------------------------------------
// dual_pid_speed_controller_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef DUAL_PID_SPEED_CONTROLLER_DEFINES_SVH
`define DUAL_PID_SPEED_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DPSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define DPSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dpsc_pkg.sv]
// ----------------------------------------------------------------------------
// dpsc_pkg
// types and constants of the dual pid speed controller
// ----------------------------------------------------------------------------
package dpsc_pkg;

    localparam int unsigned SPEED_W = 16;
    localparam int unsigned ERR_W   = 17;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned LIM_W   = 15;
    localparam int unsigned IDX_W   = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_INT_LIMIT = 3'd3,
        CFG_DRV_LIMIT = 3'd4
    } t_cfg_idx;

    // input item operations
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd21760;
    localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd435;
    localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd0;
    localparam logic [LIM_W-1:0]  INT_LIMIT_RST = 15'd500;
    localparam logic [LIM_W-1:0]  DRV_LIMIT_RST = 15'd999;

    // pipeline control from the top level to each channel
    typedef struct packed {
        logic load_in;
        logic move_a;
        logic move_b;
        logic move_c;
        logic clr;
    } t_pipe_ctl;

endpackage

[rtl/dpsc_channel.sv]
// ----------------------------------------------------------------------------
// dpsc_channel
// one pid channel: error and integral stage, product stage, sum/clamp stage
// ----------------------------------------------------------------------------
module dpsc_channel
    import dpsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_pipe_ctl                 i_ctl,
    input  logic signed [SPEED_W-1:0] i_target,
    input  logic signed [SPEED_W-1:0] i_measured,
    input  logic [GAIN_W-1:0]         i_gain_p,
    input  logic [GAIN_W-1:0]         i_gain_i,
    input  logic [GAIN_W-1:0]         i_gain_d,
    input  logic [LIM_W-1:0]          i_int_limit,
    input  logic [LIM_W-1:0]          i_drv_limit,
    output logic signed [SPEED_W-1:0] o_drive
);

    // input register
    logic signed [SPEED_W-1:0] r_target;
    logic signed [SPEED_W-1:0] r_measured;

    // loop state
    logic signed [SPEED_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last;

    // stage b
    logic signed [ERR_W-1:0]   r_err_b;
    logic signed [SPEED_W-1:0] r_int_b;
    logic signed [ERR_W:0]     r_dif_b;

    // stage c
    logic signed [33:0] r_prod_p;
    logic signed [32:0] r_prod_i;
    logic signed [34:0] r_prod_d;

    logic signed [SPEED_W-1:0] r_drive;

    // stage a logic
    logic signed [ERR_W-1:0]   w_err;
    logic signed [ERR_W:0]     w_sum_i;
    logic signed [ERR_W:0]     w_lim_i;
    logic signed [ERR_W:0]     w_nlim_i;
    logic signed [SPEED_W-1:0] n_integ;
    logic signed [ERR_W:0]     w_dif;

    // stage b logic
    logic signed [33:0] w_prod_p;
    logic signed [32:0] w_prod_i;
    logic signed [34:0] w_prod_d;

    // stage c logic
    logic signed [35:0] w_acc;
    logic signed [35:0] w_lim_d;
    logic signed [35:0] w_nlim_d;
    logic signed [35:0] w_clamp;
    logic signed [35:0] w_adj;
    logic signed [SPEED_W-1:0] n_drive;

    always_comb begin
        w_err    = {r_target[SPEED_W-1], r_target} - {r_measured[SPEED_W-1], r_measured};
        w_sum_i  = {{2{r_integ[SPEED_W-1]}}, r_integ} + {w_err[ERR_W-1], w_err};
        w_lim_i  = $signed({3'b000, i_int_limit});
        w_nlim_i = -w_lim_i;
        if (w_sum_i > w_lim_i) begin
            n_integ = w_lim_i[SPEED_W-1:0];
        end else if (w_sum_i < w_nlim_i) begin
            n_integ = w_nlim_i[SPEED_W-1:0];
        end else begin
            n_integ = w_sum_i[SPEED_W-1:0];
        end
        w_dif = {w_err[ERR_W-1], w_err} - {r_last[ERR_W-1], r_last};
    end

    always_comb begin
        w_prod_p = $signed({1'b0, i_gain_p}) * r_err_b;
        w_prod_i = $signed({1'b0, i_gain_i}) * r_int_b;
        w_prod_d = $signed({1'b0, i_gain_d}) * r_dif_b;
    end

    always_comb begin
        w_acc    = {{2{r_prod_p[33]}}, r_prod_p} + {{3{r_prod_i[32]}}, r_prod_i}
                 + {r_prod_d[34], r_prod_d};
        w_lim_d  = $signed({13'd0, i_drv_limit, 8'd0});
        w_nlim_d = -w_lim_d;
        if (w_acc > w_lim_d) begin
            w_clamp = w_lim_d;
        end else if (w_acc < w_nlim_d) begin
            w_clamp = w_nlim_d;
        end else begin
            w_clamp = w_acc;
        end
        // round toward zero
        w_adj   = w_clamp[35] ? (w_clamp + 36'sd255) : w_clamp;
        n_drive = w_adj[23:8];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_target   <= i_target;
            r_measured <= i_measured;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_ctl.move_a) begin
            if (i_ctl.clr) begin
                r_integ <= '0;
                r_last  <= '0;
            end else begin
                r_integ <= n_integ;
                r_last  <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.move_a) begin
            if (i_ctl.clr) begin
                r_err_b <= '0;
                r_int_b <= '0;
                r_dif_b <= '0;
            end else begin
                r_err_b <= w_err;
                r_int_b <= n_integ;
                r_dif_b <= w_dif;
            end
        end
        if (i_ctl.move_b) begin
            r_prod_p <= w_prod_p;
            r_prod_i <= w_prod_i;
            r_prod_d <= w_prod_d;
        end
        if (i_ctl.move_c) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

[rtl/dual_pid_speed_controller.sv]
// ----------------------------------------------------------------------------
// dual_pid_speed_controller
// two-channel positional pid with integral and drive clamps
//
// channel   valid          ready          payload
// input     i_in_valid     o_in_ready     i_op, i_target_*, i_measured_*
// output    o_out_valid    i_out_ready    o_drive_left, o_drive_right
// config    i_cfg_valid    o_cfg_ready    i_cfg_index, i_cfg_data
//
// one item per cycle while the output side does not stall; an item passes the input
// register, stage b, stage c and the output register in turn; the integral and
// previous-error update closes within the first stage; output stall backs up the
// four stages in turn, each holds its item; synchronous active-low reset clears valid
// bits and loop state and loads the config registers with their reset values; config port is ready outside reset
// ----------------------------------------------------------------------------
module dual_pid_speed_controller
    import dpsc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic signed [SPEED_W-1:0] i_target_left,
    input  logic signed [SPEED_W-1:0] i_measured_left,
    input  logic signed [SPEED_W-1:0] i_target_right,
    input  logic signed [SPEED_W-1:0] i_measured_right,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SPEED_W-1:0] o_drive_left,
    output logic signed [SPEED_W-1:0] o_drive_right,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [IDX_W-1:0]          i_cfg_index,
    input  logic [GAIN_W-1:0]         i_cfg_data
);

    logic [GAIN_W-1:0] r_gain_p;
    logic [GAIN_W-1:0] r_gain_i;
    logic [GAIN_W-1:0] r_gain_d;
    logic [LIM_W-1:0]  r_int_limit;
    logic [LIM_W-1:0]  r_drv_limit;

    logic r_va;
    logic r_vb;
    logic r_vc;
    logic r_vo;
    logic r_op_a;

    logic w_out_free;
    logic w_c_free;
    logic w_b_free;
    logic w_a_free;
    logic w_accept;
    t_pipe_ctl w_ctl;

    always_comb begin
        w_out_free    = !r_vo || i_out_ready;
        w_ctl.move_c  = r_vc && w_out_free;
        w_c_free      = !r_vc || w_ctl.move_c;
        w_ctl.move_b  = r_vb && w_c_free;
        w_b_free      = !r_vb || w_ctl.move_b;
        w_ctl.move_a  = r_va && w_b_free;
        w_a_free      = !r_va || w_ctl.move_a;
        w_accept      = i_in_valid && w_a_free && i_rst_n;
        w_ctl.load_in = w_accept;
        w_ctl.clr     = (r_op_a == OP_CLEAR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_va <= w_accept || (r_va && !w_ctl.move_a);
            r_vb <= w_ctl.move_a || (r_vb && !w_ctl.move_b);
            r_vc <= w_ctl.move_b || (r_vc && !w_ctl.move_c);
            r_vo <= w_ctl.move_c || (r_vo && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op_a <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= GAIN_P_RST;
            r_gain_i    <= GAIN_I_RST;
            r_gain_d    <= GAIN_D_RST;
            r_int_limit <= INT_LIMIT_RST;
            r_drv_limit <= DRV_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN_P:    r_gain_p    <= i_cfg_data;
                CFG_GAIN_I:    r_gain_i    <= i_cfg_data;
                CFG_GAIN_D:    r_gain_d    <= i_cfg_data;
                CFG_INT_LIMIT: r_int_limit <= i_cfg_data[LIM_W-1:0];
                CFG_DRV_LIMIT: r_drv_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    dpsc_channel u_left (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_target    (i_target_left),
        .i_measured  (i_measured_left),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_int_limit (r_int_limit),
        .i_drv_limit (r_drv_limit),
        .o_drive     (o_drive_left)
    );

    dpsc_channel u_right (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_target    (i_target_right),
        .i_measured  (i_measured_right),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_int_limit (r_int_limit),
        .i_drv_limit (r_drv_limit),
        .o_drive     (o_drive_right)
    );

    assign o_in_ready  = w_a_free && i_rst_n;
    assign o_out_valid = r_vo;
    assign o_cfg_ready = i_rst_n;

endmodule

[rtl/dpsc_checker.sv]
// ----------------------------------------------------------------------------
// dpsc_checker
// port-level checks of the dual pid speed controller
// ----------------------------------------------------------------------------
`include "dual_pid_speed_controller_defines.svh"

module dpsc_checker
    import dpsc_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic signed [SPEED_W-1:0] o_drive_left,
    input logic signed [SPEED_W-1:0] o_drive_right
);

    `DPSC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "output valid dropped before transfer")
    `DPSC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_drive_left) && $stable(o_drive_right), "output payload changed under stall")
    `DPSC_ASSERT_NOW(a_drive_range, o_out_valid, o_drive_left != 16'sh8000 && o_drive_right != 16'sh8000, "drive outside symmetric clamp range")
    `DPSC_ASSERT_NOW(a_reset_empty, $rose(i_rst_n), !o_out_valid, "output valid right after reset")

endmodule

bind dual_pid_speed_controller dpsc_checker u_dpsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_drive_left  (o_drive_left),
    .o_drive_right (o_drive_right)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the dual pid speed controller
//
// a predictor tracks gains, limits, integrals and previous errors
// and queues the expected drive pair for every input transfer; a monitor pops
// the queue on each output transfer and compares both drives; directed items
// hit the speed extremes, clear, clamps, zero limits and fractional
// truncation, then random phases under varied register settings and random
// stalls on both sides, with one long output hold to back up the pipeline
// ----------------------------------------------------------------------------
module tb;
    import dpsc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RST_CYCLES  = 6;
    localparam int PIPE_DEPTH  = 4;
    localparam int TAIL_CYCLES = 2 * PIPE_DEPTH;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 120;
    localparam int HOLD_CYCLES = 40;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
    } t_drive_pair;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_op;
    logic signed [SPEED_W-1:0] i_target_left;
    logic signed [SPEED_W-1:0] i_measured_left;
    logic signed [SPEED_W-1:0] i_target_right;
    logic signed [SPEED_W-1:0] i_measured_right;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [SPEED_W-1:0] o_drive_left;
    logic signed [SPEED_W-1:0] o_drive_right;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [IDX_W-1:0]          i_cfg_index;
    logic [GAIN_W-1:0]         i_cfg_data;

    // predictor copy of the registers and loop state
    logic [GAIN_W-1:0] gain_p_q;
    logic [GAIN_W-1:0] gain_i_q;
    logic [GAIN_W-1:0] gain_d_q;
    logic [LIM_W-1:0]  int_limit_q;
    logic [LIM_W-1:0]  drv_limit_q;
    longint            integral_st [2];
    longint            last_err_st [2];

    t_drive_pair expected_drives [$];
    int          error_count;
    int          cycle_count;
    bit          idle_en;
    int          out_hold_len;

    dual_pid_speed_controller uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_target_left    (i_target_left),
        .i_measured_left  (i_measured_left),
        .i_target_right   (i_target_right),
        .i_measured_right (i_measured_right),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_drive_left     (o_drive_left),
        .o_drive_right    (o_drive_right),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("error at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic longint sym_clamp(input longint v, input longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic logic signed [SPEED_W-1:0] pid_channel(
        input int ch,
        input logic signed [SPEED_W-1:0] tgt,
        input logic signed [SPEED_W-1:0] meas
    );
        longint kp, ki, kd, ilim, dlim, err, integ, acc;
        kp    = gain_p_q;
        ki    = gain_i_q;
        kd    = gain_d_q;
        ilim  = int_limit_q;
        dlim  = drv_limit_q;
        err   = longint'(tgt) - longint'(meas);
        integ = sym_clamp(integral_st[ch] + err, ilim);
        integral_st[ch] = integ;
        acc   = kp * err + ki * integ + kd * (err - last_err_st[ch]);
        last_err_st[ch] = err;
        // clamp on the exact q8.8 sum, then truncate toward zero
        acc   = sym_clamp(acc, dlim * 256) / 256;
        return acc[SPEED_W-1:0];
    endfunction

    function automatic t_drive_pair predict_drives(
        input logic op,
        input logic signed [SPEED_W-1:0] tl,
        input logic signed [SPEED_W-1:0] ml,
        input logic signed [SPEED_W-1:0] tr,
        input logic signed [SPEED_W-1:0] mr
    );
        t_drive_pair res;
        res = '0;
        if (op == OP_CLEAR) begin
            integral_st[0] = 0;
            integral_st[1] = 0;
            last_err_st[0] = 0;
            last_err_st[1] = 0;
        end else begin
            res.left  = pid_channel(0, tl, ml);
            res.right = pid_channel(1, tr, mr);
        end
        return res;
    endfunction

    // output side ready, with random stalls and the long hold
    initial begin
        forever begin
            if (out_hold_len > 0) begin
                i_out_ready <= 1'b0;
                repeat (out_hold_len) @(posedge i_clk);
                out_hold_len = 0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // result monitor
    initial begin
        t_drive_pair exp_d;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_drives.size() == 0) begin
                    report_error($sformatf("unexpected result left %0d right %0d",
                                           o_drive_left, o_drive_right));
                end else begin
                    exp_d = expected_drives.pop_front();
                    if (o_drive_left !== exp_d.left) begin
                        report_error($sformatf("drive_left got %0d expected %0d",
                                               o_drive_left, exp_d.left));
                    end
                    if (o_drive_right !== exp_d.right) begin
                        report_error($sformatf("drive_right got %0d expected %0d",
                                               o_drive_right, exp_d.right));
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("** dual_pid_speed_controller: FAILED **");
        $finish;
    end

    task automatic send_item(
        input logic op,
        input logic signed [SPEED_W-1:0] tl,
        input logic signed [SPEED_W-1:0] ml,
        input logic signed [SPEED_W-1:0] tr,
        input logic signed [SPEED_W-1:0] mr
    );
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_op             <= op;
        i_target_left    <= tl;
        i_measured_left  <= ml;
        i_target_right   <= tr;
        i_measured_right <= mr;
        do @(posedge i_clk); while (!o_in_ready);
        expected_drives.push_back(predict_drives(op, tl, ml, tr, mr));
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_drives.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_GAIN_P:    gain_p_q    = data;
            CFG_GAIN_I:    gain_i_q    = data;
            CFG_GAIN_D:    gain_d_q    = data;
            CFG_INT_LIMIT: int_limit_q = data[LIM_W-1:0];
            CFG_DRV_LIMIT: drv_limit_q = data[LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(
        input logic [GAIN_W-1:0] gp,
        input logic [GAIN_W-1:0] gi,
        input logic [GAIN_W-1:0] gd,
        input logic [GAIN_W-1:0] il,
        input logic [GAIN_W-1:0] dl
    );
        cfg_write(CFG_GAIN_P, gp);
        cfg_write(CFG_GAIN_I, gi);
        cfg_write(CFG_GAIN_D, gd);
        cfg_write(CFG_INT_LIMIT, il);
        cfg_write(CFG_DRV_LIMIT, dl);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom_range(0, 1023));
            3:       return GAIN_W'($urandom_range(0, 65535));
            default: return GAIN_W'($urandom_range(64, 8192));
        endcase
    endfunction

    // limit word, top bit random since only the low 15 bits count
    function automatic logic [GAIN_W-1:0] rand_limit();
        logic [GAIN_W-1:0] w;
        case ($urandom_range(0, 5))
            0:       w = '0;
            1:       w = 16'h7FFF;
            2:       w = GAIN_W'($urandom_range(1, 2000));
            3:       w = GAIN_W'($urandom_range(0, 32767));
            default: w = GAIN_W'($urandom_range(100, 8000));
        endcase
        w[GAIN_W-1] = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic logic signed [SPEED_W-1:0] near_speed(
        input logic signed [SPEED_W-1:0] base,
        input int spread
    );
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic signed [SPEED_W-1:0] edge_speed();
        case ($urandom_range(0, 3))
            0:       return SPEED_MAX;
            1:       return SPEED_MIN;
            2:       return '0;
            default: return SPEED_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random_item();
        logic signed [SPEED_W-1:0] tl, ml, tr, mr;
        int mode, spread;
        tl = SPEED_W'($urandom_range(0, 65535));
        tr = SPEED_W'($urandom_range(0, 65535));
        ml = SPEED_W'($urandom_range(0, 65535));
        mr = SPEED_W'($urandom_range(0, 65535));
        mode = $urandom_range(0, 29);
        if (mode == 0) begin
            send_item(OP_CLEAR, tl, ml, tr, mr);
        end else if (mode < 22) begin
            // tracking loop: measurement close to target
            case ($urandom_range(0, 2))
                0:       spread = 4;
                1:       spread = 40;
                default: spread = 400;
            endcase
            send_item(OP_UPDATE, tl, near_speed(tl, spread), tr, near_speed(tr, spread));
        end else if (mode < 27) begin
            send_item(OP_UPDATE, tl, ml, tr, mr);
        end else begin
            send_item(OP_UPDATE, edge_speed(), edge_speed(), edge_speed(), edge_speed());
        end
    endtask

    task automatic test_reset_values();
        idle_en = 1'b0;
        send_item(OP_UPDATE, '0, '0, '0, '0);
        send_item(OP_UPDATE, SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
        send_item(OP_UPDATE, SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
        send_item(OP_UPDATE, 16'sd3, 16'sd0, -16'sd3, 16'sd0);
        send_item(OP_CLEAR, SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
        send_item(OP_UPDATE, 16'sd10, 16'sd12, -16'sd7, -16'sd2);
        stop_input();
        wait_drain();
    endtask

    task automatic test_extreme_settings();
        cfg_write(CFG_UNUSED, '1);
        apply_settings('1, '1, '1, 16'h7FFF, 16'h7FFF);
        send_item(OP_UPDATE, SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
        // largest derivative step in both directions
        send_item(OP_UPDATE, SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN);
        send_item(OP_UPDATE, '0, '0, '0, '0);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        stop_input();
        wait_drain();
        // zero limits
        apply_settings('1, '1, '1, 16'h8000, 16'h8000);
        send_item(OP_UPDATE, SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
        send_item(OP_UPDATE, SPEED_MIN, SPEED_MAX, SPEED_MAX, SPEED_MIN);
        stop_input();
        wait_drain();
        // zero gains
        apply_settings('0, '0, '0, 16'hFFFF, 16'hFFFF);
        send_item(OP_UPDATE, SPEED_MAX, SPEED_MIN, SPEED_MIN, SPEED_MAX);
        stop_input();
        wait_drain();
    endtask

    task automatic test_fraction_truncation();
        apply_settings(16'd256, '0, '0, 16'h7FFF, 16'h7FFF);
        send_item(OP_UPDATE, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
        stop_input();
        wait_drain();
        // half gain: odd errors land between integers
        apply_settings(16'd128, '0, '0, 16'h7FFF, 16'h7FFF);
        send_item(OP_UPDATE, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
        send_item(OP_UPDATE, 16'sd3, 16'sd0, -16'sd3, 16'sd0);
        stop_input();
        wait_drain();
    endtask

    task automatic test_backpressure();
        apply_settings(16'd256, 16'd64, 16'd128, 16'd1000, 16'd30000);
        idle_en = 1'b0;
        out_hold_len = HOLD_CYCLES;
        repeat (30) send_random_item();
        stop_input();
        wait_drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph == 0) begin
                apply_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST,
                               16'(INT_LIMIT_RST), 16'(DRV_LIMIT_RST));
            end else begin
                apply_settings(rand_gain(), rand_gain(), rand_gain(),
                               rand_limit(), rand_limit());
            end
            idle_en = ($urandom_range(0, 2) != 0);
            repeat (PHASE_ITEMS) send_random_item();
            stop_input();
            wait_drain();
        end
    endtask

    task automatic test_steady_stream();
        apply_settings(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit());
        idle_en = 1'b0;
        repeat (80) send_random_item();
        stop_input();
        wait_drain();
    endtask

    initial begin
        error_count  = 0;
        idle_en      = 1'b0;
        out_hold_len = 0;
        gain_p_q     = GAIN_P_RST;
        gain_i_q     = GAIN_I_RST;
        gain_d_q     = GAIN_D_RST;
        int_limit_q  = INT_LIMIT_RST;
        drv_limit_q  = DRV_LIMIT_RST;
        integral_st[0] = 0;
        integral_st[1] = 0;
        last_err_st[0] = 0;
        last_err_st[1] = 0;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_op             <= OP_UPDATE;
        i_target_left    <= '0;
        i_measured_left  <= '0;
        i_target_right   <= '0;
        i_measured_right <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_GAIN_P;
        i_cfg_data       <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_extreme_settings();
        test_fraction_truncation();
        test_backpressure();
        test_random_phases();
        test_steady_stream();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_drives.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_drives.size()));
        end
        if (error_count == 0) begin
            $display("** dual_pid_speed_controller: PASSED **");
        end else begin
            $display("** dual_pid_speed_controller: FAILED **");
        end
        $finish;
    end

endmodule
